### design/hte_pkg.sv
`timescale 1ns / 1ps

package hte_pkg;

    // Field widths of the beats on both channels
    localparam int CMD_W     = 2;
    localparam int SYM_W     = 8;
    localparam int WORD_W    = 32;
    localparam int LEN_W     = 6;
    localparam int BYTE_W    = 8;
    localparam int TOTAL_W   = 40;

    // Defaults for the top level parameters
    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOLS      = 256;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } t_cmd;

endpackage

### design/hte_if.sv
`timescale 1ns / 1ps

interface hte_in_if;
    logic                          valid;
    logic                          ready;
    logic [hte_pkg::CMD_W-1:0]     cmd;
    logic [hte_pkg::SYM_W-1:0]     symbol;
    logic [hte_pkg::WORD_W-1:0]    code_word;
    logic [hte_pkg::LEN_W-1:0]     code_len;

    modport source (output valid, cmd, symbol, code_word, code_len, input ready);
    modport sink   (input valid, cmd, symbol, code_word, code_len, output ready);
endinterface

interface hte_out_if;
    logic                          valid;
    logic                          ready;
    logic [hte_pkg::BYTE_W-1:0]    out_byte;
    logic                          last;
    logic                          final_byte;
    logic [hte_pkg::TOTAL_W-1:0]   bits_written;

    modport source (output valid, out_byte, last, final_byte, bits_written, input ready);
    modport sink   (input valid, out_byte, last, final_byte, bits_written, output ready);
endinterface

### design/huffman_table_encoder_bit_packer_top.sv
// Path: encode and flush beats are registered in the lookup stage, then load the output queue.
// Throughput: one input beat per cycle while the output is ready and each item yields at most
//   one byte; an item of n bytes holds the packer stage for n output beats (up to (MAX_CODE_LEN+7)/8).
// Reset (i_rst_n low, synchronous): clears the length valid bits, the packer, the bit count and
//   all pipeline/queue control. The code word table is not cleared; no clearing pass is needed.
`timescale 1ns / 1ps

module huffman_table_encoder_bit_packer_top #(
    parameter int MAX_CODE_LEN = hte_pkg::MAX_CODE_LEN,
    parameter int SYMBOLS      = hte_pkg::SYMBOLS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hte_in_if.sink       i_in,
    hte_out_if.source    o_out
);

    // Derived sizes
    localparam int IW  = $clog2(SYMBOLS);             // table index
    localparam int LW  = $clog2(MAX_CODE_LEN + 1);    // stored code length
    localparam int SW  = MAX_CODE_LEN + 8;            // pending bits + one code
    localparam int TW  = $clog2(SW + 1);              // bit count of that stream
    localparam int NB  = (MAX_CODE_LEN + 7) / 8;      // most bytes one encode can emit
    localparam int QIW = (NB > 1) ? $clog2(NB) : 1;   // queue read index
    localparam int QCW = $clog2(NB + 1);              // queue fill count
    localparam int DW  = MAX_CODE_LEN + LW;           // table word: {length, code}

    // ------------------------------------------------------------------
    // Input side: table write for loads, registered table read for the rest
    // ------------------------------------------------------------------
    logic                        in_fire;
    logic                        sym_ok;
    logic [IW-1:0]               in_idx;
    logic [LW-1:0]               in_len;
    logic [MAX_CODE_LEN+31:0]    word_ext;
    logic [MAX_CODE_LEN-1:0]     in_code;

    // Code table: memory; only lengths carry a valid bit so unwritten entries read as no code
    logic [DW-1:0]               r_table [SYMBOLS];
    logic [SYMBOLS-1:0]          r_tab_vld;

    // Lookup stage
    logic                        r_a_vld;
    logic [hte_pkg::CMD_W-1:0]   r_a_cmd;
    logic                        r_a_hit;
    logic [DW-1:0]               r_a_data;
    logic                        a_take;

    assign in_fire  = i_in.valid && i_in.ready;
    assign sym_ok   = {1'b0, i_in.symbol} < (hte_pkg::SYM_W + 1)'(SYMBOLS);
    assign in_idx   = i_in.symbol[IW-1:0];
    // Overlong lengths clamp to the longest code the packer takes
    assign in_len   = ((hte_pkg::LEN_W + 2)'(i_in.code_len) > (hte_pkg::LEN_W + 2)'(MAX_CODE_LEN))
                      ? LW'(MAX_CODE_LEN) : LW'(i_in.code_len);
    // Code bits beyond the 32-bit word read as zero
    assign word_ext = {{MAX_CODE_LEN{1'b0}}, i_in.code_word};
    assign in_code  = word_ext[MAX_CODE_LEN-1:0];

    assign i_in.ready = !r_a_vld || a_take;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (i_in.cmd == hte_pkg::CMD_LOAD && sym_ok) begin
                r_table[in_idx] <= {in_len, in_code};
            end
            r_a_data <= r_table[in_idx];
            r_a_cmd  <= i_in.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_vld <= '0;
            r_a_vld   <= 1'b0;
            r_a_hit   <= 1'b0;
        end else begin
            if (in_fire) begin
                if (i_in.cmd == hte_pkg::CMD_LOAD && sym_ok) begin
                    r_tab_vld[in_idx] <= 1'b1;
                end
                r_a_hit <= sym_ok && r_tab_vld[in_idx];
                // loads and unknown commands end here
                r_a_vld <= (i_in.cmd == hte_pkg::CMD_ENCODE) || (i_in.cmd == hte_pkg::CMD_FLUSH);
            end else if (a_take) begin
                r_a_vld <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Packer stage: barrel-shift the whole code against the pending bits
    // ------------------------------------------------------------------
    logic [3:0]                  r_pend;    // 0..8 pending bits; 8 = full byte held
    logic [7:0]                  r_buf;     // pending bits, right aligned
    logic [hte_pkg::TOTAL_W-1:0] r_total;

    logic [LW-1:0]               a_len;
    logic [MAX_CODE_LEN-1:0]     a_code;
    logic [MAX_CODE_LEN-1:0]     code_m;
    logic [SW-1:0]               stream;
    logic [SW-1:0]               aligned;
    logic [TW-1:0]               tot_bits;
    logic [QCW-1:0]              enc_n;
    logic [3:0]                  enc_pend;
    logic [7:0]                  enc_buf;
    logic [15:0]                 fl_wide;

    logic [QCW-1:0]              n_cnt;     // bytes this item pushes
    logic                        n_is_flush;
    logic [3:0]                  n_pend;
    logic [7:0]                  n_buf;
    logic [hte_pkg::TOTAL_W-1:0] n_total;
    logic                        n_upd;     // packer state changes

    assign a_len    = r_a_hit ? r_a_data[DW-1 -: LW] : '0;
    assign a_code   = r_a_data[MAX_CODE_LEN-1:0];
    assign code_m   = a_code & ~({MAX_CODE_LEN{1'b1}} << a_len);
    assign stream   = (SW'(r_buf) << a_len) | SW'(code_m);
    assign tot_bits = TW'(r_pend) + TW'(a_len);
    // left align so byte k sits at a fixed slice
    assign aligned  = stream << (TW'(SW) - tot_bits);
    // a full byte is held back until a later bit arrives, hence the minus one
    assign enc_n    = QCW'((tot_bits - TW'(1)) >> 3);
    assign enc_pend = 4'(tot_bits - (TW'(enc_n) << 3));
    assign enc_buf  = stream[7:0] & ~(8'hFF << enc_pend);
    assign fl_wide  = {8'd0, r_buf} << (4'd8 - r_pend);

    always_comb begin
        n_cnt      = '0;
        n_is_flush = 1'b0;
        n_pend     = r_pend;
        n_buf      = r_buf;
        n_total    = r_total;
        n_upd      = 1'b0;
        unique case (r_a_cmd)
            hte_pkg::CMD_ENCODE: begin
                if (a_len != '0) begin
                    n_cnt   = enc_n;
                    n_pend  = enc_pend;
                    n_buf   = enc_buf;
                    n_total = r_total + hte_pkg::TOTAL_W'(a_len);
                    n_upd   = 1'b1;
                end
            end
            hte_pkg::CMD_FLUSH: begin
                n_cnt      = QCW'(1);
                n_is_flush = 1'b1;
                n_pend     = '0;
                n_buf      = '0;
                n_total    = '0;
                n_upd      = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output queue: bytes of one item, sent one per beat
    // ------------------------------------------------------------------
    logic [7:0]                  r_q_byte [NB];
    logic [QCW-1:0]              r_q_cnt;
    logic [QIW-1:0]              r_q_idx;
    logic                        r_q_flush;
    logic [hte_pkg::TOTAL_W-1:0] r_q_total;
    logic                        out_fire;
    logic                        q_last;
    logic                        q_free;

    assign q_last   = (QCW'(r_q_idx) + QCW'(1)) == r_q_cnt;
    assign out_fire = o_out.valid && o_out.ready;
    assign q_free   = (r_q_cnt == '0) || (out_fire && q_last);
    assign a_take   = r_a_vld && ((n_cnt == '0) || q_free);

    assign o_out.valid        = r_q_cnt != '0;
    assign o_out.out_byte     = r_q_byte[r_q_idx];
    assign o_out.last         = q_last;
    assign o_out.final_byte   = r_q_flush;
    assign o_out.bits_written = r_q_total;

    always_ff @(posedge i_clk) begin
        if (a_take && n_cnt != '0) begin
            for (int k = 0; k < NB; k++) begin
                // a flush sends only the padded byte in slot 0
                r_q_byte[k] <= (n_is_flush && k == 0) ? fl_wide[7:0] : aligned[SW-1-8*k -: 8];
            end
            r_q_flush <= n_is_flush;
            r_q_total <= n_is_flush ? r_total : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_buf   <= '0;
            r_total <= '0;
            r_q_cnt <= '0;
            r_q_idx <= '0;
        end else begin
            if (a_take && n_upd) begin
                r_pend  <= n_pend;
                r_buf   <= n_buf;
                r_total <= n_total;
            end
            if (a_take && n_cnt != '0) begin
                r_q_cnt <= n_cnt;
                r_q_idx <= '0;
            end else if (out_fire) begin
                if (q_last) begin
                    r_q_cnt <= '0;
                    r_q_idx <= '0;
                end else begin
                    r_q_idx <= r_q_idx + QIW'(1);
                end
            end
        end
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import hte_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_BEATS = 456;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_START   = 400;
    localparam int HOLD_CYCLES  = 250;
    localparam int POOL_N       = 16;
    localparam int N_DIR        = 24;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic               is_last;
        logic               is_final;
        logic [TOTAL_W-1:0] total;
    } t_byte_beat;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [SYM_W-1:0]   sym;
        logic [WORD_W-1:0]  word;
        logic [LEN_W-1:0]   len;
        int                 typed_n;   // -1: use the packer model, else bytes typed below
        logic [BYTE_W-1:0]  t_byte;
        logic [TOTAL_W-1:0] t_total;
    } t_code_beat;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    hte_in_if  in_if ();
    hte_out_if out_if ();

    huffman_table_encoder_bit_packer_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Packer model: code tables, pending bits and the running bit count
    logic [WORD_W-1:0]  cw_table [SYMBOLS];
    logic [LEN_W-1:0]   cl_table [SYMBOLS];
    logic [BYTE_W-1:0]  pk_buf;
    logic [2:0]         pk_fill;
    logic [TOTAL_W-1:0] pk_total;
    logic               pk_any;

    t_byte_beat exp_bytes_q [$];

    int  n_errors = 0;
    int  n_in_beats = 0;
    int  n_bytes = 0;
    int  n_flushes = 0;
    int  n_quad = 0;
    int  burst_left = 1;
    bit  hold_active = 1'b0;

    t_code_beat dir_rows [N_DIR] = '{
        //  cmd          sym    word            len    typed byte   total
        '{CMD_FLUSH,   8'h00, 32'h0000_0000, 6'd0,  1,    8'h00, 40'd0},  // nothing written yet
        '{CMD_ENCODE,  8'h00, 32'h0000_0000, 6'd0,  0,    8'h00, 40'd0},  // no code: skipped
        '{CMD_UNUSED,  8'hFF, 32'hFFFF_FFFF, 6'd63, 0,    8'h00, 40'd0},  // unknown command
        '{CMD_LOAD,    8'h00, 32'h0000_00A5, 6'd8,  0,    8'h00, 40'd0},
        '{CMD_ENCODE,  8'h00, 32'h0000_0000, 6'd0,  0,    8'h00, 40'd0},  // full byte held back
        '{CMD_FLUSH,   8'h00, 32'h0000_0000, 6'd0,  1,    8'hA5, 40'd8},
        '{CMD_LOAD,    8'hFF, 32'hFFFF_FFFF, 6'd32, 0,    8'h00, 40'd0},
        '{CMD_LOAD,    8'h80, 32'h0000_0001, 6'd1,  0,    8'h00, 40'd0},
        '{CMD_ENCODE,  8'h80, 32'h0000_0000, 6'd0,  -1,   8'h00, 40'd0},
        '{CMD_ENCODE,  8'hFF, 32'h0000_0000, 6'd0,  -1,   8'h00, 40'd0},
        '{CMD_FLUSH,   8'h00, 32'h0000_0000, 6'd0,  -1,   8'h00, 40'd0},
        '{CMD_LOAD,    8'h55, 32'h1234_5678, 6'd63, 0,    8'h00, 40'd0},  // length clamps
        '{CMD_ENCODE,  8'h55, 32'h0000_0000, 6'd0,  -1,   8'h00, 40'd0},
        '{CMD_ENCODE,  8'hFF, 32'h0000_0000, 6'd0,  -1,   8'h00, 40'd0},  // four bytes out
        '{CMD_FLUSH,   8'h00, 32'h0000_0000, 6'd0,  -1,   8'h00, 40'd0},
        '{CMD_LOAD,    8'h80, 32'h0000_0000, 6'd0,  0,    8'h00, 40'd0},  // code removed
        '{CMD_ENCODE,  8'h80, 32'h0000_0000, 6'd0,  0,    8'h00, 40'd0},
        '{CMD_FLUSH,   8'h00, 32'h0000_0000, 6'd0,  1,    8'h00, 40'd0},
        '{CMD_LOAD,    8'h01, 32'hAAAA_AAAB, 6'd2,  0,    8'h00, 40'd0},
        '{CMD_LOAD,    8'h02, 32'h5555_5550, 6'd3,  0,    8'h00, 40'd0},
        '{CMD_ENCODE,  8'h01, 32'h0000_0000, 6'd0,  -1,   8'h00, 40'd0},
        '{CMD_ENCODE,  8'h02, 32'h0000_0000, 6'd0,  -1,   8'h00, 40'd0},
        '{CMD_ENCODE,  8'h01, 32'h0000_0000, 6'd0,  -1,   8'h00, 40'd0},
        '{CMD_FLUSH,   8'h00, 32'h0000_0000, 6'd0,  -1,   8'h00, 40'd0}
    };

    // Every byte value is a valid symbol at SYMBOLS = 256.
    task automatic predict_packed_bytes(input t_code_beat b, ref t_byte_beat res[$]);
        int                clen;
        int                pend;
        logic [BYTE_W-1:0] held;
        res.delete();
        pend = (pk_fill == 3'd0 && pk_any) ? 8 : int'(pk_fill);
        case (b.cmd)
            CMD_LOAD: begin
                cw_table[b.sym] = b.word;
                cl_table[b.sym] = (b.len > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : b.len;
            end
            CMD_ENCODE: begin
                clen = int'(cl_table[b.sym]);
                for (int i = clen; i > 0; i--) begin
                    // a full byte leaves only when the next code bit shows up
                    if (pend == 8) begin
                        res.push_back(t_byte_beat'{pk_buf, 1'b0, 1'b0, '0});
                        pk_buf = '0;
                        pend   = 0;
                    end
                    pk_buf   = {pk_buf[BYTE_W-2:0], cw_table[b.sym][i-1]};
                    pend     = pend + 1;
                    pk_total = pk_total + 1'b1;
                end
                if (clen > 0) begin
                    pk_fill = 3'(pend);
                    pk_any  = (pend > 0);
                end
                if (res.size() > 0) res[res.size()-1].is_last = 1'b1;
            end
            CMD_FLUSH: begin
                held = (pend > 0) ? BYTE_W'(pk_buf << (8 - pend)) : '0;
                res.push_back(t_byte_beat'{held, 1'b1, 1'b1, pk_total});
                pk_buf   = '0;
                pk_fill  = '0;
                pk_any   = 1'b0;
                pk_total = '0;
            end
            default: ;
        endcase
    endtask

    task automatic send_code_beat(input t_code_beat b);
        t_byte_beat res[$];
        int         gap;
        in_if.valid     <= 1'b1;
        in_if.cmd       <= b.cmd;
        in_if.symbol    <= b.sym;
        in_if.code_word <= b.word;
        in_if.code_len  <= b.len;
        do @(posedge i_clk); while (!in_if.ready);
        predict_packed_bytes(b, res);
        if (b.typed_n >= 0) begin
            res.delete();
            if (b.typed_n > 0) res.push_back(t_byte_beat'{b.t_byte, 1'b1, 1'b1, b.t_total});
        end
        foreach (res[k]) exp_bytes_q.push_back(res[k]);
        n_in_beats++;
        if (b.cmd == CMD_FLUSH) n_flushes++;
        if (b.cmd == CMD_ENCODE && res.size() == 4) n_quad++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            // no gaps while the output is held off, so the input backs up
            if (gap > 0 && !hold_active) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic void check_field(string name, logic [TOTAL_W-1:0] want,
                                        logic [TOTAL_W-1:0] got);
        if (got !== want) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_byte_beat want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            n_bytes++;
            if (exp_bytes_q.size() == 0) begin
                n_errors++;
                $display("%0t: byte %h arrived with nothing expected", $time, out_if.out_byte);
            end else begin
                want = exp_bytes_q.pop_front();
                check_field("out_byte", TOTAL_W'(want.data), TOTAL_W'(out_if.out_byte));
                check_field("last", TOTAL_W'(want.is_last), TOTAL_W'(out_if.last));
                check_field("final_byte", TOTAL_W'(want.is_final), TOTAL_W'(out_if.final_byte));
                check_field("bits_written", want.total, out_if.bits_written);
            end
        end
    end

    // Output side: the stall pattern switches among four modes during the run, with one long hold-off
    initial begin
        int cyc;
        int mode;
        cyc  = 0;
        mode = 0;
        out_if.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            if (cyc == HOLD_START) begin
                hold_active = 1'b1;
                out_if.ready <= 1'b0;
                for (int h = 0; h < HOLD_CYCLES; h++) @(posedge i_clk);
                hold_active = 1'b0;
            end else begin
                case (mode)
                    0:       out_if.ready <= 1'b1;
                    1:       out_if.ready <= 1'($urandom_range(0, 1));
                    2:       out_if.ready <= (cyc % 4 != 3);
                    default: out_if.ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge i_clk);
            end
            cyc++;
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
            else idle++;
        end
        $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_code_beat        b;
        logic [SYM_W-1:0]  pool [POOL_N];
        int                n_real;
        int                pick;
        in_if.valid     <= 1'b0;
        in_if.cmd       <= '0;
        in_if.symbol    <= '0;
        in_if.code_word <= '0;
        in_if.code_len  <= '0;
        foreach (cl_table[s]) cl_table[s] = '0;
        pk_buf   = '0;
        pk_fill  = '0;
        pk_total = '0;
        pk_any   = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) send_code_beat(dir_rows[r]);

        // Random part: codes mostly land on a small symbol pool so encodes find them
        foreach (pool[p]) pool[p] = SYM_W'($urandom);
        n_real = 0;
        while (n_in_beats < N_DIR + RANDOM_BEATS) begin
            pick      = $urandom_range(0, 99);
            b.typed_n = -1;
            b.t_byte  = '0;
            b.t_total = '0;
            b.word    = $urandom;
            b.len     = LEN_W'($urandom);
            b.sym     = pool[$urandom_range(0, POOL_N - 1)];
            if (pick < 16) begin
                b.cmd = CMD_LOAD;
                case ($urandom_range(0, 9))
                    0:       b.len = '0;
                    1:       b.len = LEN_W'($urandom_range(MAX_CODE_LEN + 1, 63));
                    2, 3, 4: b.len = LEN_W'($urandom_range(9, MAX_CODE_LEN));
                    default: b.len = LEN_W'($urandom_range(1, 8));
                endcase
                if ($urandom_range(0, 4) == 0) b.sym = SYM_W'($urandom);
            end else if (pick < 86) begin
                b.cmd = CMD_ENCODE;
            end else if (pick < 95) begin
                b.cmd = CMD_FLUSH;
            end else if (pick < 98) begin
                b.cmd = CMD_ENCODE;        // stray symbol, usually without a code
                b.sym = SYM_W'($urandom);
            end else begin
                b.cmd = CMD_UNUSED;
            end
            if (b.cmd == CMD_LOAD || b.cmd == CMD_FLUSH ||
                (b.cmd == CMD_ENCODE && cl_table[b.sym] != '0)) n_real++;
            send_code_beat(b);
        end
        in_if.valid <= 1'b0;

        while (exp_bytes_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d input beats (%0d effective random), %0d output bytes checked,",
                 n_in_beats, n_real, n_bytes);
        $display("  %0d flushes, %0d four-byte encodes and one %0d-cycle output hold-off",
                 n_flushes, n_quad, HOLD_CYCLES);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
